// ----- sv/sdeu_pkg.sv -----
// Shared types and constants of the step sequencer direction engine.
// No dependencies; used by sdeu_track_update and the top level.
package sdeu_pkg;

   typedef enum logic [2:0] {
      KIND_TICK      = 3'd0,
      KIND_EXT_CLK   = 3'd1,
      KIND_RST_EDGE  = 3'd2,
      KIND_RST_LEVEL = 3'd3,
      KIND_PLAY      = 3'd4,
      KIND_STOP      = 3'd5,
      KIND_NEXT_DIR  = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      DIR_FWD      = 3'd0,
      DIR_REV      = 3'd1,
      DIR_PEND     = 3'd2,
      DIR_WOBBLE   = 3'd3,
      DIR_HOP      = 3'd4,
      DIR_RAND     = 3'd5,
      DIR_RAND_SIL = 3'd6
   } dir_type;

   typedef enum logic [1:0] {
      RK_PLAY   = 2'd0,
      RK_SILENT = 2'd1,
      RK_DIR    = 2'd2
   } rkind_type;

   typedef enum logic [1:0] {
      RM_START  = 2'd0,
      RM_HOLD   = 2'd1,
      RM_INVERT = 2'd2
   } rmode_type;

   typedef enum logic [2:0] {
      CSR_TEMPO   = 3'd0,
      CSR_SOURCE  = 3'd1,
      CSR_RMODE   = 3'd2,
      CSR_LENGTHS = 3'd3,
      CSR_DIVS    = 3'd4
   } csr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic [1:0] {
      OP_STEP,
      OP_INVERT,
      OP_DIR
   } op_type;

   typedef struct packed {
      logic       silenced;
      logic [2:0] step;
      logic [2:0] dir;
   } res_type;

   localparam int          NDIRS          = 7;
   localparam int          RAND_W         = 16;
   localparam int          RANGE_W        = 7;
   localparam int          STAGGER_RANGE  = 100;
   localparam int          STAGGER_DOUBLE = 25;
   localparam int          STAGGER_BACK   = 50;
   localparam logic [15:0] TEMPO_RST      = 16'd12000;
   localparam logic [15:0] LENGTHS_RST    = 16'h8888;
   localparam logic [15:0] DIVS_RST       = 16'h1111;

   localparam logic [2:0] FLIP [8] = '{3'd1, 3'd0, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0};

endpackage

// ----- sv/sdeu_req_if.sv -----
// Input channel of the step sequencer direction engine: valid, ready, event fields.
// No dependencies.
interface sdeu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [1:0]  track;
   logic        level;
   logic [63:0] random_bits;

   modport source (output valid, kind, track, level, random_bits, input ready);
   modport sink (input valid, kind, track, level, random_bits, output ready);
endinterface

// ----- sv/sdeu_rsp_if.sv -----
// Result channel of the step sequencer direction engine: valid, ready, result fields.
// No dependencies.
interface sdeu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [1:0] out_track;
   logic [2:0] step;
   logic [2:0] direction;
   logic       last;

   modport source (output valid, result_kind, out_track, step, direction, last, input ready);
   modport sink (input valid, result_kind, out_track, step, direction, last, output ready);
endinterface

// ----- sv/sdeu_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sdeu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sdeu_track_update.sv -----
// Read-modify-write datapath for one track record: stepping, inversion, direction requests.
// Depends on sdeu_pkg.
module sdeu_track_update #(
   parameter int MAX_STEPS = 8
) (
   input  sdeu_pkg::op_type                      op,
   input  logic                                  inv_phase,
   input  logic [$clog2(MAX_STEPS+1)-1:0]        len,
   input  logic [sdeu_pkg::RAND_W-1:0]           rnd,
   input  logic                                  valid_i,
   input  logic [2*$clog2(MAX_STEPS)+9:0]        rec_i,
   output logic                                  valid_o,
   output logic [2*$clog2(MAX_STEPS)+9:0]        rec_o,
   output sdeu_pkg::res_type                     res
);

   localparam int POS_W = $clog2(MAX_STEPS);
   localparam int LEN_W = $clog2(MAX_STEPS+1);
   localparam int RW    = sdeu_pkg::RANGE_W;

   function automatic logic [POS_W-1:0] fwd(input logic [POS_W-1:0] p, input logic v,
                                            input logic [LEN_W-1:0] l);
      logic [LEN_W:0] n;
      n = v ? (LEN_W+1)'(p) + (LEN_W+1)'(1) : '0;
      if (n >= (LEN_W+1)'(l)) begin
         n = '0;
      end
      return POS_W'(n);
   endfunction

   function automatic logic [POS_W-1:0] bwd(input logic [POS_W-1:0] p, input logic v,
                                            input logic [LEN_W-1:0] l);
      if (!v || p == '0) begin
         return POS_W'(l - LEN_W'(1));
      end
      return p - POS_W'(1);
   endfunction

   function automatic logic [RW-1:0] scale(input logic [sdeu_pkg::RAND_W-1:0] r,
                                           input logic [RW-1:0] range);
      logic [sdeu_pkg::RAND_W+RW-1:0] m;
      m = (sdeu_pkg::RAND_W+RW)'(r) * (sdeu_pkg::RAND_W+RW)'(range);
      return m[sdeu_pkg::RAND_W+RW-1:sdeu_pkg::RAND_W];
   endfunction

   logic [POS_W-1:0] pos, sk, npos, nsk, tmp;
   logic [2:0]       dir, sav, pend, ndir, nsav, npend, ans;
   logic             pb, npb, nv, sil;
   logic [RW-1:0]    sv;
   logic [3:0]       sum;

   always_comb begin
      {pos, dir, sav, pb, sk, pend} = rec_i;
      npos  = pos;
      nv    = valid_i;
      ndir  = dir;
      nsav  = sav;
      npb   = pb;
      nsk   = sk;
      npend = pend;
      sil   = 1'b0;
      ans   = '0;
      sv    = '0;
      tmp   = '0;
      sum   = '0;
      unique case (op)
         sdeu_pkg::OP_STEP: begin
            nv = 1'b1;
            case (dir)
               sdeu_pkg::DIR_REV: npos = bwd(pos, valid_i, len);
               sdeu_pkg::DIR_PEND: begin
                  if (!pb) begin
                     if (valid_i && (LEN_W+1)'(pos) == (LEN_W+1)'(len) - (LEN_W+1)'(1)) begin
                        npb  = 1'b1;
                        npos = bwd(pos, valid_i, len);
                     end else begin
                        npos = fwd(pos, valid_i, len);
                     end
                  end else begin
                     if (valid_i && pos == '0) begin
                        npb  = 1'b0;
                        npos = fwd(pos, valid_i, len);
                     end else begin
                        npos = bwd(pos, valid_i, len);
                     end
                  end
               end
               sdeu_pkg::DIR_WOBBLE: begin
                  sv = scale(rnd, RW'(sdeu_pkg::STAGGER_RANGE));
                  if (sv < RW'(sdeu_pkg::STAGGER_DOUBLE)) begin
                     tmp  = fwd(pos, valid_i, len);
                     npos = fwd(tmp, 1'b1, len);
                  end else if (sv < RW'(sdeu_pkg::STAGGER_BACK)) begin
                     npos = bwd(pos, valid_i, len);
                  end else begin
                     npos = fwd(pos, valid_i, len);
                  end
               end
               sdeu_pkg::DIR_HOP: begin
                  tmp = fwd(pos, valid_i, len);
                  if (tmp == sk) begin
                     nsk  = fwd(sk, 1'b1, len);
                     npos = fwd(tmp, 1'b1, len);
                  end else begin
                     npos = tmp;
                  end
               end
               sdeu_pkg::DIR_RAND: begin
                  sv   = scale(rnd, RW'(len));
                  npos = POS_W'(sv);
               end
               sdeu_pkg::DIR_RAND_SIL: begin
                  sv = scale(rnd, RW'(len) + RW'(1));
                  if (sv >= RW'(len)) begin
                     nv   = 1'b0;
                     npos = '0;
                     sil  = 1'b1;
                  end else begin
                     npos = POS_W'(sv);
                  end
               end
               default: npos = fwd(pos, valid_i, len);
            endcase
            if (nv && npos == '0) begin
               for (int i = 1; i < sdeu_pkg::NDIRS; i++) begin
                  if (i <= int'(pend)) begin
                     ndir = (ndir == 3'(sdeu_pkg::NDIRS - 1)) ? 3'd0 : ndir + 3'd1;
                     if (ndir == sdeu_pkg::DIR_PEND) begin
                        npb = 1'b0;
                     end
                     if (ndir == sdeu_pkg::DIR_HOP) begin
                        nsk = '0;
                     end
                  end
               end
               npend = '0;
            end
         end
         sdeu_pkg::OP_INVERT: begin
            if (!inv_phase) begin
               nsav = dir;
               ndir = sdeu_pkg::FLIP[dir];
            end else begin
               ndir = sav;
            end
            if (ndir == sdeu_pkg::DIR_PEND) begin
               npb = 1'b0;
            end
            if (ndir == sdeu_pkg::DIR_HOP) begin
               nsk = '0;
            end
         end
         sdeu_pkg::OP_DIR: begin
            npend = (pend == 3'(sdeu_pkg::NDIRS - 1)) ? 3'd0 : pend + 3'd1;
            sum   = 4'(dir) + 4'(npend);
            ans   = (sum >= 4'(sdeu_pkg::NDIRS)) ? 3'(sum - 4'(sdeu_pkg::NDIRS)) : 3'(sum);
         end
         default: ;
      endcase
      rec_o        = {npos, ndir, nsav, npb, nsk, npend};
      valid_o      = nv;
      res.silenced = sil;
      res.step     = sil ? 3'd0 : 3'(npos);
      res.dir      = ans;
   end

endmodule

// ----- sv/step_sequencer_direction_engine_unit.sv -----
// Top level of the step sequencer direction engine: timebase, control sequencer, track RAM.
// Depends on sdeu_pkg, sdeu_req_if, sdeu_rsp_if, sdeu_ram and sdeu_track_update.
//
//   channel  dir  handshake              contents
//   req      in   valid/ready            kind, track, level, random_bits
//   rsp      out  valid/ready            result_kind, out_track, step, direction, last
//   csr      in   csr_wr_en only         csr_index, csr_wdata (16 bits)
//
// An item that causes no track work launches no sweep. A step event or reset-edge inversion
// sweeps every track record, a direction request its own: the accepting cycle reads the first
// record, then each is updated, written back (on a step, if it fires) and the next one read.
// After reset a clearing pass zeroes the track RAM; req.ready stays low.
// A result waiting in the output register stalls the sweep only when the next one is due.
module step_sequencer_direction_engine_unit #(
   parameter int TRACKS      = 4,
   parameter int MAX_STEPS   = 8,
   parameter int MAX_DIVISOR = 8
) (
   input  logic              clock,
   input  logic              reset,
   sdeu_req_if.sink          req,
   sdeu_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int POS_W = $clog2(MAX_STEPS);
   localparam int LEN_W = $clog2(MAX_STEPS+1);
   localparam int CNT_W = (MAX_DIVISOR > 1) ? $clog2(MAX_DIVISOR) : 1;
   localparam int TI_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int REC_W = 2*POS_W + 10;

   // configuration
   logic [15:0] tempo_ticks_ff, lengths_ff, divs_ff;
   logic        source_ff;
   logic [1:0]  rmode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ticks_ff <= sdeu_pkg::TEMPO_RST;
         source_ff      <= 1'b0;
         rmode_ff       <= sdeu_pkg::RM_START;
         lengths_ff     <= sdeu_pkg::LENGTHS_RST;
         divs_ff        <= sdeu_pkg::DIVS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sdeu_pkg::CSR_TEMPO:   tempo_ticks_ff <= csr_wdata;
            sdeu_pkg::CSR_SOURCE:  source_ff      <= csr_wdata[0];
            sdeu_pkg::CSR_RMODE:   rmode_ff       <= csr_wdata[1:0];
            sdeu_pkg::CSR_LENGTHS: lengths_ff     <= csr_wdata;
            sdeu_pkg::CSR_DIVS:    divs_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   sdeu_pkg::state_type state_ff, state_in;
   sdeu_pkg::op_type    op_ff, op_in;
   logic [15:0]         tempo_ff, tempo_in;
   logic                playing_ff, playing_in, level_ff, level_in, phase_ff, phase_in;
   logic [TI_W-1:0]     trk_ff, trk_in;
   logic [TRACKS-1:0]   pv_ff, pv_in, fire_ff, fire_in;
   logic [CNT_W-1:0]    div_ff [TRACKS];
   logic [CNT_W-1:0]    div_in [TRACKS];
   logic [63:0]         rnd_ff, rnd_in;

   logic                rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in, rsp_track_ff, rsp_track_in;
   logic [2:0]          rsp_step_ff, rsp_step_in, rsp_dir_ff, rsp_dir_in;

   logic                ram_wr_en, ram_rd_en;
   logic [TI_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [REC_W-1:0]    ram_wr_data, ram_rd_data, upd_rec;
   logic                upd_valid;
   sdeu_pkg::res_type   upd_res;

   logic [1:0]          tsel;
   logic [4:0]          len_w, nib, dv, cnt;
   logic [LEN_W-1:0]    cur_len;
   logic [15:0]         cur_rnd, tc;
   logic                ev, go, out_free, need_out, stall, sweep_done, later_fire;
   logic                trk_fire, trk_pv;

   assign tsel     = 2'(trk_ff);
   assign cur_rnd  = rnd_ff[{tsel, 4'b0000} +: 16];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign trk_fire = fire_ff[trk_ff];
   assign trk_pv   = pv_ff[trk_ff];

   always_comb begin
      nib = (32'(trk_ff) < 4) ? 5'(lengths_ff[{tsel, 2'b00} +: 4]) : 5'd0;
      len_w = nib;
      if (len_w < 5'd2) begin
         len_w = 5'd2;
      end
      if (len_w > 5'(MAX_STEPS)) begin
         len_w = 5'(MAX_STEPS);
      end
      cur_len = LEN_W'(len_w);
   end

   always_comb begin
      later_fire = 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
         if (i > int'(trk_ff) && fire_ff[i]) begin
            later_fire = 1'b1;
         end
      end
   end

   assign need_out   = (op_ff == sdeu_pkg::OP_DIR) || (op_ff == sdeu_pkg::OP_STEP && trk_fire);
   assign stall      = need_out && !out_free;
   assign sweep_done = (op_ff == sdeu_pkg::OP_DIR) || (trk_ff == TI_W'(TRACKS - 1));

   // decide whether an accepted item launches a sweep
   always_comb begin
      tc = tempo_ff;
      ev = 1'b0;
      go = 1'b0;
      if (tempo_ff != 16'd0) begin
         tc = tempo_ff - 16'd1;
      end
      unique case (req.kind)
         sdeu_pkg::KIND_TICK:     ev = !source_ff && tc == 16'd0;
         sdeu_pkg::KIND_EXT_CLK:  ev = source_ff;
         sdeu_pkg::KIND_RST_EDGE: go = rmode_ff == sdeu_pkg::RM_INVERT;
         sdeu_pkg::KIND_NEXT_DIR: go = 32'(req.track) < TRACKS;
         default: ;
      endcase
      ev = ev && playing_ff && !(rmode_ff == sdeu_pkg::RM_HOLD && !level_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdeu_pkg::ST_CLEAR: begin
            if (trk_ff == TI_W'(TRACKS - 1)) begin
               state_in = sdeu_pkg::ST_IDLE;
            end
         end
         sdeu_pkg::ST_IDLE: begin
            if (req.valid && (go || (ev && (|fire_in)))) begin
               state_in = sdeu_pkg::ST_RUN;
            end
         end
         sdeu_pkg::ST_RUN: begin
            if (!stall && sweep_done) begin
               state_in = sdeu_pkg::ST_IDLE;
            end
         end
         default: state_in = sdeu_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in        = op_ff;
      tempo_in     = tempo_ff;
      playing_in   = playing_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      trk_in       = trk_ff;
      pv_in        = pv_ff;
      fire_in      = fire_ff;
      div_in       = div_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_track_in = rsp_track_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = trk_ff;
      ram_wr_data  = upd_rec;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = trk_ff;
      req.ready    = 1'b0;
      dv           = '0;
      cnt          = '0;
      unique case (state_ff)
         sdeu_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            trk_in      = (trk_ff == TI_W'(TRACKS - 1)) ? '0 : trk_ff + TI_W'(1);
         end
         sdeu_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               unique case (req.kind)
                  sdeu_pkg::KIND_TICK: tempo_in = ev || (!source_ff && tc == 16'd0)
                                                  ? tempo_ticks_ff : tc;
                  sdeu_pkg::KIND_RST_EDGE: begin
                     if (rmode_ff == sdeu_pkg::RM_START) begin
                        pv_in = '0;
                        for (int t = 0; t < TRACKS; t++) begin
                           div_in[t] = '0;
                        end
                     end else if (go) begin
                        op_in  = sdeu_pkg::OP_INVERT;
                        trk_in = '0;
                     end
                  end
                  sdeu_pkg::KIND_RST_LEVEL: level_in = req.level;
                  sdeu_pkg::KIND_PLAY: begin
                     pv_in      = '0;
                     playing_in = 1'b1;
                     tempo_in   = '0;
                     for (int t = 0; t < TRACKS; t++) begin
                        div_in[t] = '0;
                     end
                  end
                  sdeu_pkg::KIND_STOP: playing_in = 1'b0;
                  sdeu_pkg::KIND_NEXT_DIR: begin
                     if (go) begin
                        op_in  = sdeu_pkg::OP_DIR;
                        trk_in = TI_W'(req.track);
                     end
                  end
                  default: ;
               endcase
               if (ev) begin
                  for (int t = 0; t < TRACKS; t++) begin
                     dv = (t < 4) ? 5'(divs_ff[4*(t%4) +: 4]) : 5'd0;
                     if (dv == 5'd0) begin
                        dv = 5'd1;
                     end
                     if (dv > 5'(MAX_DIVISOR)) begin
                        dv = 5'(MAX_DIVISOR);
                     end
                     cnt = 5'(div_ff[t]) + 5'd1;
                     if (cnt < dv) begin
                        div_in[t]  = CNT_W'(cnt);
                        fire_in[t] = 1'b0;
                     end else begin
                        div_in[t]  = '0;
                        fire_in[t] = 1'b1;
                     end
                  end
                  op_in  = sdeu_pkg::OP_STEP;
                  rnd_in = req.random_bits;
                  trk_in = '0;
               end
               ram_rd_en   = 1'b1;
               ram_rd_addr = trk_in;
            end
         end
         sdeu_pkg::ST_RUN: begin
            if (!stall) begin
               ram_wr_en = (op_ff != sdeu_pkg::OP_STEP) || trk_fire;
               if (op_ff == sdeu_pkg::OP_STEP && trk_fire) begin
                  pv_in[trk_ff] = upd_valid;
               end
               if (need_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_track_in = tsel;
                  if (op_ff == sdeu_pkg::OP_DIR) begin
                     rsp_kind_in = sdeu_pkg::RK_DIR;
                     rsp_step_in = '0;
                     rsp_dir_in  = upd_res.dir;
                     rsp_last_in = 1'b1;
                  end else begin
                     rsp_kind_in = upd_res.silenced ? sdeu_pkg::RK_SILENT : sdeu_pkg::RK_PLAY;
                     rsp_step_in = upd_res.step;
                     rsp_dir_in  = '0;
                     rsp_last_in = !later_fire;
                  end
               end
               if (sweep_done) begin
                  if (op_ff == sdeu_pkg::OP_INVERT) begin
                     phase_in = !phase_ff;
                  end
               end else begin
                  trk_in      = trk_ff + TI_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = trk_ff + TI_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdeu_pkg::ST_CLEAR;
         op_ff        <= sdeu_pkg::OP_STEP;
         tempo_ff     <= '0;
         playing_ff   <= 1'b0;
         level_ff     <= 1'b1;
         phase_ff     <= 1'b0;
         trk_ff       <= '0;
         pv_ff        <= '0;
         fire_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TRACKS; t++) begin
            div_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         tempo_ff     <= tempo_in;
         playing_ff   <= playing_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         trk_ff       <= trk_in;
         pv_ff        <= pv_in;
         fire_ff      <= fire_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff       <= rnd_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_track_ff <= rsp_track_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.out_track   = rsp_track_ff;
   assign rsp.step        = rsp_step_ff;
   assign rsp.direction   = rsp_dir_ff;
   assign rsp.last        = rsp_last_ff;

   sdeu_ram #(
      .WIDTH (REC_W),
      .DEPTH (TRACKS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sdeu_track_update #(
      .MAX_STEPS (MAX_STEPS)
   ) u_track_update (
      .op        (op_ff),
      .inv_phase (phase_ff),
      .len       (cur_len),
      .rnd       (cur_rnd),
      .valid_i   (trk_pv),
      .rec_i     (ram_rd_data),
      .valid_o   (upd_valid),
      .rec_o     (upd_rec),
      .res       (upd_res)
   );

`ifndef NO_ASSERTIONS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("track RAM read and write hit the same entry");

   a_dir_answer_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == sdeu_pkg::RK_DIR) |-> rsp_last_ff)
      else $error("direction answer not marked last");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdeu_pkg::ST_CLEAR || state_ff == sdeu_pkg::ST_RUN) |-> !req.ready)
      else $error("item accepted during sweep");
`endif

endmodule
